### hw/rtl/mbsd_pkg.sv
// ----------------------------------------------------------------------------
// mbsd_pkg
// shared types, target codes and address constants of the bank switch decoder
// ----------------------------------------------------------------------------
`default_nettype none

package mbsd_pkg;

  // target codes
  localparam logic [2:0] TGT_MAIN    = 3'd0;
  localparam logic [2:0] TGT_AUX     = 3'd1;
  localparam logic [2:0] TGT_BASIC   = 3'd2;
  localparam logic [2:0] TGT_MONITOR = 3'd3;
  localparam logic [2:0] TGT_DISK    = 3'd4;
  localparam logic [2:0] TGT_FLOPPY  = 3'd5;
  localparam logic [2:0] TGT_IO      = 3'd6;
  localparam logic [2:0] TGT_DROPPED = 3'd7;

  // memory map
  localparam logic [15:0] ADDR_ZP_END      = 16'h0200;
  localparam logic [15:0] ADDR_IO_BASE     = 16'hC000;
  localparam logic [15:0] ADDR_CARD_BASE   = 16'hD000;
  localparam logic [15:0] ADDR_CARD_HIGH   = 16'hE000;
  localparam logic [15:0] ADDR_MONITOR     = 16'hF800;
  localparam logic [7:0]  PAGE_DISK_ROM    = 8'hC6;
  localparam logic [11:0] BLK_FLOPPY       = 12'hC0E;
  localparam logic [11:0] BLK_CARD_SWITCH  = 12'hC08;
  localparam logic [15:0] MASK_BANK        = 16'h0FFF;
  localparam logic [15:0] MASK_MONITOR     = 16'h07FF;

  // switch pairs, even address of each pair
  localparam logic [15:0] SW_TEXT   = 16'hC050;
  localparam logic [15:0] SW_MIXED  = 16'hC052;
  localparam logic [15:0] SW_PAGE2  = 16'hC054;
  localparam logic [15:0] SW_HIRES  = 16'hC056;
  localparam logic [15:0] SW_80STORE = 16'hC000;
  localparam logic [15:0] SW_RAMRD  = 16'hC002;
  localparam logic [15:0] SW_RAMWRT = 16'hC004;
  localparam logic [15:0] SW_ALTZP  = 16'hC008;

  // soft switch state
  typedef struct packed {
    logic alt_zero_page;
    logic aux_read;
    logic aux_write;
    logic store_80col;
    logic page_two;
    logic hires_mode;
    logic text_display;
    logic mixed_display;
    logic card_read_enable;
    logic card_write_inhibit;
    logic card_prewrite;
    logic card_bank_high;
  } sw_state_t;

  localparam sw_state_t SW_RESET = '{
    alt_zero_page:      1'b0,
    aux_read:           1'b0,
    aux_write:          1'b0,
    store_80col:        1'b0,
    page_two:           1'b0,
    hires_mode:         1'b0,
    text_display:       1'b1,
    mixed_display:      1'b1,
    card_read_enable:   1'b0,
    card_write_inhibit: 1'b0,
    card_prewrite:      1'b0,
    card_bank_high:     1'b1
  };

  // one decoded access
  typedef struct packed {
    logic [2:0]  target;
    logic [15:0] mem_offset;
    logic        video_text;
    logic        video_mixed;
    logic        video_page2;
    logic        video_hires;
  } dec_result_t;

endpackage

`default_nettype wire

### hw/rtl/mbsd_switch_regs.sv
// ----------------------------------------------------------------------------
// mbsd_switch_regs
// soft switch register file, loaded once per decoded access
// ----------------------------------------------------------------------------
`default_nettype none

module mbsd_switch_regs (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  upd_en,
  input  mbsd_pkg::sw_state_t  sw_nxt,
  output mbsd_pkg::sw_state_t  sw_cur
);
  import mbsd_pkg::*;

  sw_state_t sw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SW_RESET;
    end else if (upd_en) begin
      sw_r <= sw_nxt;
    end
  end

  assign sw_cur = sw_r;

endmodule

`default_nettype wire

### hw/rtl/mbsd_decode.sv
// ----------------------------------------------------------------------------
// mbsd_decode
// address decode of one bus access and soft switch next state
// ----------------------------------------------------------------------------
`default_nettype none

module mbsd_decode (
  input  wire [15:0]             address,
  input  wire                    is_write,
  input  mbsd_pkg::sw_state_t    sw_cur,
  output mbsd_pkg::sw_state_t    sw_nxt,
  output mbsd_pkg::dec_result_t  result
);
  import mbsd_pkg::*;

  logic        sel_aux;
  logic        card_en;
  logic [15:0] pair_addr;
  logic [2:0]  tgt;
  logic [15:0] off;

  assign pair_addr = {address[15:1], 1'b0};

  always_comb begin
    sw_nxt  = sw_cur;
    tgt     = TGT_MAIN;
    off     = address;
    sel_aux = 1'b0;
    card_en = 1'b0;
    if (address < ADDR_IO_BASE) begin
      // main or aux ram below the io page
      sel_aux = is_write ? sw_cur.aux_write : sw_cur.aux_read;
      if (address < ADDR_ZP_END) begin
        sel_aux = sw_cur.alt_zero_page;
      end else if (address[15:10] == 6'b000001 && sw_cur.store_80col) begin
        sel_aux = sw_cur.page_two;
      end else if (address[15:13] == 3'b001 && sw_cur.store_80col && sw_cur.hires_mode) begin
        sel_aux = sw_cur.page_two;
      end
      tgt = sel_aux ? TGT_AUX : TGT_MAIN;
    end else if (address < ADDR_CARD_BASE) begin
      if (!is_write && address[15:8] == PAGE_DISK_ROM) begin
        tgt = TGT_DISK;
        off = {8'h00, address[7:0]};
      end else if (address[15:4] == BLK_FLOPPY) begin
        tgt = TGT_FLOPPY;
        off = {12'h000, address[3:0]};
      end else begin
        tgt = TGT_IO;
        off = address - ADDR_IO_BASE;
        if (address[15:4] == BLK_CARD_SWITCH) begin
          // language card control
          sw_nxt.card_bank_high   = address[3];
          sw_nxt.card_read_enable = (address[1] == address[0]);
          if (address[0]) begin
            if (!is_write && sw_cur.card_prewrite) begin
              sw_nxt.card_write_inhibit = 1'b0;
            end
            sw_nxt.card_prewrite = !is_write;
          end else begin
            sw_nxt.card_write_inhibit = 1'b1;
            sw_nxt.card_prewrite      = 1'b0;
          end
        end else if (pair_addr == SW_TEXT) begin
          sw_nxt.text_display = address[0];
        end else if (pair_addr == SW_MIXED) begin
          sw_nxt.mixed_display = address[0];
        end else if (pair_addr == SW_PAGE2) begin
          sw_nxt.page_two = address[0];
        end else if (pair_addr == SW_HIRES) begin
          sw_nxt.hires_mode = address[0];
        end else if (is_write) begin
          if (pair_addr == SW_80STORE) begin
            sw_nxt.store_80col = address[0];
          end else if (pair_addr == SW_RAMRD) begin
            sw_nxt.aux_read = address[0];
          end else if (pair_addr == SW_RAMWRT) begin
            sw_nxt.aux_write = address[0];
          end else if (pair_addr == SW_ALTZP) begin
            sw_nxt.alt_zero_page = address[0];
          end
        end
      end
    end else begin
      // language card window or rom; writes with the card write-inhibited are dropped
      card_en = is_write ? !sw_cur.card_write_inhibit : sw_cur.card_read_enable;
      if (card_en) begin
        tgt = sw_cur.alt_zero_page ? TGT_AUX : TGT_MAIN;
        if (address < ADDR_CARD_HIGH) begin
          off = (sw_cur.card_bank_high ? ADDR_CARD_BASE : ADDR_IO_BASE) |
                (address & MASK_BANK);
        end
      end else if (is_write) begin
        tgt = TGT_DROPPED;
        off = 16'h0000;
      end else if (address < ADDR_MONITOR) begin
        tgt = TGT_BASIC;
        off = address - ADDR_CARD_BASE;
      end else begin
        tgt = TGT_MONITOR;
        off = address & MASK_MONITOR;
      end
    end
  end

  assign result.target      = tgt;
  assign result.mem_offset  = off;
  assign result.video_text  = sw_nxt.text_display;
  assign result.video_mixed = sw_nxt.mixed_display;
  assign result.video_page2 = sw_nxt.page_two;
  assign result.video_hires = sw_nxt.hires_mode;

endmodule

`default_nettype wire

### hw/rtl/memory_bank_switch_decoder_core.sv
// ----------------------------------------------------------------------------
// memory_bank_switch_decoder_core
// bank switch decoder for 64k main, 64k aux and a 16k language card
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser
// in_      in   [15:0] address                 [0] is_write
// out_     out  [15:0] mem_offset, [16] text,  [2:0] target
//               [17] mixed, [18] page2,
//               [19] hires, [23:20] zero
//
// one word per cycle sustained while the output is not stalled; the path runs
// through input register, decode and result register
// the decode and the soft switch update happen in the same cycle, so each
// word sees the switches as left by the word before it
// rst_n is synchronous: switches return to power-up values, both stages empty
// a stalled output holds the input stage, and in_tready drops only when
// both stages are full
// ----------------------------------------------------------------------------
`default_nettype none

module memory_bank_switch_decoder_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // [15:0] address
  input  wire [0:0]  in_tuser,   // [0] is_write
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [23:0] out_tdata, // [15:0] mem_offset, [16] video_text, [17] video_mixed,
                                 // [18] video_page2, [19] video_hires, [23:20] zero
  output logic [2:0] out_tuser   // [2:0] target
);
  import mbsd_pkg::*;

  // input stage
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [15:0] s1_addr_r;
  logic        s1_wr_r;

  // result stage
  logic        out_valid_r;
  logic        out_valid_nxt;
  dec_result_t out_res_r;

  // decode
  sw_state_t   sw_cur;
  sw_state_t   sw_nxt;
  dec_result_t dec_res;
  logic        advance;

  // move the input word into the result stage when that stage frees up
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign s1_valid_nxt  = (in_tvalid && in_tready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_addr_r <= in_tdata;
      s1_wr_r   <= in_tuser[0];
    end
    if (advance) begin
      out_res_r <= dec_res;
    end
  end

  mbsd_decode u_decode (
    .address  (s1_addr_r),
    .is_write (s1_wr_r),
    .sw_cur   (sw_cur),
    .sw_nxt   (sw_nxt),
    .result   (dec_res)
  );

  // switches change only as a word leaves the input stage
  mbsd_switch_regs u_switches (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .sw_nxt (sw_nxt),
    .sw_cur (sw_cur)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {4'h0, out_res_r.video_hires, out_res_r.video_page2,
                       out_res_r.video_mixed, out_res_r.video_text,
                       out_res_r.mem_offset};

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result stage valid after reset");

  // switches do not move while the decode is held back
  a_sw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> $stable(sw_cur))
    else $error("switch state changed during output stall");

  // a dropped write carries a zero offset
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == TGT_DROPPED) |-> (out_tdata[15:0] == 16'h0000))
    else $error("dropped write with nonzero offset");

  // floppy and disk rom offsets stay inside their windows
  a_dev_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == TGT_FLOPPY || out_tuser == TGT_DISK))
      |-> (out_tdata[15:8] == 8'h00))
    else $error("device offset out of range");

  // reported text and hires bits match the switch registers right after the update
  a_video_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_tdata[16] == sw_cur.text_display &&
                 out_tdata[19] == sw_cur.hires_mode))
    else $error("video bits disagree with switch state");

endmodule

`default_nettype wire
